### rtl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
`default_nettype none
package spq_pkg;

    localparam int ID_W  = 16;
    localparam int PRI_W = 2;
    localparam int OCC_W = 5;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_ADMIT  = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_REMOVE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

endpackage
`default_nettype wire

### rtl/spq_req_if.sv
// Request channel: operation code, identifier and priority.
`default_nettype none
interface spq_req_if;
    logic                         valid;
    logic                         ready;
    spq_pkg::mode_t               mode;
    logic [spq_pkg::ID_W-1:0]     item_id;
    logic [spq_pkg::PRI_W-1:0]    priority_req;

    modport source (output valid, output mode, output item_id, output priority_req,
                    input ready);
    modport sink   (input valid, input mode, input item_id, input priority_req,
                    output ready);
endinterface
`default_nettype wire

### rtl/spq_rsp_if.sv
// Response channel: status, popped entry and occupancy.
`default_nettype none
interface spq_rsp_if;
    logic                         valid;
    logic                         ready;
    spq_pkg::status_t             status;
    logic [spq_pkg::ID_W-1:0]     out_id;
    logic [spq_pkg::PRI_W-1:0]    out_priority;
    logic [spq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, output status, output out_id, output out_priority,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_id, input out_priority,
                    input occupancy, output ready);
endinterface
`default_nettype wire

### rtl/spq_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module spq_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### rtl/stable_priority_queue_by_id.sv
// Stable priority queue kept as an ordered list in one RAM.
//
//  channel | dir | fields                                   | word accepted
//  req     | in  | mode, item_id, priority_req              | valid && ready
//  rsp     | out | status, out_id, out_priority, occupancy  | valid && ready
//
// One operation at a time. Each one not refused streams the list through the RAM
// read port from the head, one entry per cycle, rewriting shifted entries behind
// the read: insert runs one slot past the tail, admit/remove to the tail, update
// to its match or the tail. Refused operations (full, empty) skip the scan.
// Reset clears the entry count; list contents need no clearing.
// A response held by rsp stall lets the next word in; it waits only to finish.
`default_nettype none
module stable_priority_queue_by_id #(
    parameter int CAPACITY = 16,
    parameter int ID_BITS  = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int KEEP_W = (ID_BITS < spq_pkg::ID_W) ? ID_BITS : spq_pkg::ID_W;
    localparam int ENT_W  = KEEP_W + spq_pkg::PRI_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                     state_reg;
    logic [CNT_W-1:0]           count_reg;
    spq_pkg::mode_t             mode_reg;
    logic [KEEP_W-1:0]          key_reg;
    logic [spq_pkg::PRI_W-1:0]  pri_reg;
    logic [IDX_W-1:0]           last_reg;
    logic [IDX_W-1:0]           issue_reg;
    logic                       issue_done_reg;
    logic                       p_valid_reg;
    logic [IDX_W-1:0]           p_idx_reg;
    logic                       hit_reg;
    logic [ENT_W-1:0]           hold_reg;
    spq_pkg::status_t           res_status_reg;
    logic [KEEP_W-1:0]          res_id_reg;
    logic [spq_pkg::PRI_W-1:0]  res_pri_reg;
    logic                       out_valid_reg;
    spq_pkg::status_t           out_status_reg;
    logic [spq_pkg::ID_W-1:0]   out_id_reg;
    logic [spq_pkg::PRI_W-1:0]  out_pri_reg;
    logic [spq_pkg::OCC_W-1:0]  out_occ_reg;

    logic                       rd_en;
    logic [ENT_W-1:0]           rd_data;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [ENT_W-1:0]           wr_data;
    logic [KEEP_W-1:0]          d_key;
    logic [spq_pkg::PRI_W-1:0]  d_pri;
    logic                       proc;
    logic                       is_last;
    logic                       at_end;
    logic                       match;
    logic                       place;
    logic                       accept;

    spq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_list (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (issue_reg),
        .rd_data (rd_data)
    );

    assign req.ready        = (state_reg == S_IDLE);
    assign accept           = req.valid && req.ready;
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.out_id       = out_id_reg;
    assign rsp.out_priority = out_pri_reg;
    assign rsp.occupancy    = out_occ_reg;

    assign rd_en   = (state_reg == S_SCAN) && !issue_done_reg;
    assign d_key   = rd_data[ENT_W-1:spq_pkg::PRI_W];
    assign d_pri   = rd_data[spq_pkg::PRI_W-1:0];
    assign proc    = (state_reg == S_SCAN) && p_valid_reg;
    assign is_last = (p_idx_reg == last_reg);
    // one past the tail: only reached by insert
    assign at_end  = (CNT_W'(p_idx_reg) == count_reg);
    assign match   = (mode_reg == spq_pkg::MODE_ADMIT) ? (p_idx_reg == '0)
                                                       : (d_key == key_reg);
    assign place   = !hit_reg && (at_end || (d_pri > pri_reg));

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = p_idx_reg;
        wr_data = {key_reg, pri_reg};
        if (proc)
        begin
            unique case (mode_reg)
                spq_pkg::MODE_INSERT:
                begin
                    if (place)
                    begin
                        wr_en = 1'b1;
                    end
                    else if (hit_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_data = hold_reg;
                    end
                end
                spq_pkg::MODE_ADMIT, spq_pkg::MODE_REMOVE:
                begin
                    // close the gap: entry moves down one slot
                    if (hit_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = p_idx_reg - IDX_W'(1);
                        wr_data = rd_data;
                    end
                end
                spq_pkg::MODE_UPDATE:
                begin
                    if (match)
                    begin
                        wr_en   = 1'b1;
                        wr_data = {d_key, pri_reg};
                    end
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            issue_done_reg <= 1'b0;
            p_valid_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            p_valid_reg <= rd_en;
            p_idx_reg   <= issue_reg;
            if (rd_en)
            begin
                issue_reg <= issue_reg + IDX_W'(1);
                if (issue_reg == last_reg)
                begin
                    issue_done_reg <= 1'b1;
                end
            end

            // the finish state reloads the output word itself
            if (rsp.ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg       <= req.mode;
                        key_reg        <= KEEP_W'(req.item_id);
                        pri_reg        <= req.priority_req;
                        hit_reg        <= 1'b0;
                        issue_reg      <= '0;
                        issue_done_reg <= 1'b0;
                        res_status_reg <= spq_pkg::STAT_OK;
                        res_id_reg     <= '0;
                        res_pri_reg    <= '0;
                        if (req.mode == spq_pkg::MODE_INSERT)
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_status_reg <= spq_pkg::STAT_FULL;
                                state_reg      <= S_FINISH;
                            end
                            else
                            begin
                                last_reg  <= IDX_W'(count_reg);
                                state_reg <= S_SCAN;
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            res_status_reg <= (req.mode == spq_pkg::MODE_UPDATE)
                                              ? spq_pkg::STAT_NOT_FOUND
                                              : spq_pkg::STAT_EMPTY;
                            state_reg      <= S_FINISH;
                        end
                        else
                        begin
                            last_reg  <= IDX_W'(count_reg - CNT_W'(1));
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (proc)
                    begin
                        unique case (mode_reg)
                            spq_pkg::MODE_INSERT:
                            begin
                                if (place || hit_reg)
                                begin
                                    hold_reg <= rd_data;
                                    hit_reg  <= 1'b1;
                                end
                                if (is_last)
                                begin
                                    count_reg <= count_reg + CNT_W'(1);
                                    state_reg <= S_FINISH;
                                end
                            end
                            spq_pkg::MODE_ADMIT, spq_pkg::MODE_REMOVE:
                            begin
                                if (!hit_reg && match)
                                begin
                                    hit_reg     <= 1'b1;
                                    res_id_reg  <= d_key;
                                    res_pri_reg <= d_pri;
                                end
                                if (is_last)
                                begin
                                    if (hit_reg || match)
                                    begin
                                        count_reg <= count_reg - CNT_W'(1);
                                    end
                                    else
                                    begin
                                        res_status_reg <= spq_pkg::STAT_NOT_FOUND;
                                    end
                                    state_reg <= S_FINISH;
                                end
                            end
                            spq_pkg::MODE_UPDATE:
                            begin
                                if (match)
                                begin
                                    state_reg <= S_FINISH;
                                end
                                else if (is_last)
                                begin
                                    res_status_reg <= spq_pkg::STAT_NOT_FOUND;
                                    state_reg      <= S_FINISH;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_id_reg     <= spq_pkg::ID_W'(res_id_reg);
                        out_pri_reg    <= res_pri_reg;
                        out_occ_reg    <= spq_pkg::OCC_W'(count_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### bench/tb_stable_priority_queue_by_id.sv
// Testbench for the stable priority queue: directed and random traffic, self-checked.
`default_nettype none
module tb_stable_priority_queue_by_id;
    import spq_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        status_t             status;
        logic [ID_W-1:0]     out_id;
        logic [PRI_W-1:0]    out_priority;
        logic [OCC_W-1:0]    occupancy;
    } rsp_word_t;

    typedef enum int {
        SEG_FILL,
        SEG_DRAIN,
        SEG_MIX
    } seg_kind_t;

    logic clk = 1'b0;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    stable_priority_queue_by_id #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_W)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the ordered list, head at index 0
    logic [ID_W-1:0]  list_tag  [CAPACITY];
    logic [PRI_W-1:0] list_rank [CAPACITY];
    int               list_len;

    rsp_word_t   awaited_rsp [$];
    int          mismatch_count = 0;
    int          sent_words;
    int          got_words = 0;
    int          status_seen [4] = '{default: 0};
    int          cycle_count = 0;
    bit          send_idle_on;
    bit          recv_idle_on;

    function automatic int find_tag(logic [ID_W-1:0] tag);
        for (int i = 0; i < list_len; i++)
        begin
            if (list_tag[i] == tag)
                return i;
        end
        return -1;
    endfunction

    function automatic void drop_entry(int pos);
        for (int i = pos; i + 1 < list_len; i++)
        begin
            list_tag[i]  = list_tag[i + 1];
            list_rank[i] = list_rank[i + 1];
        end
        list_len--;
    endfunction

    // applies one request to the shadow list and returns the response it must produce
    function automatic rsp_word_t queue_op_result(mode_t op, logic [ID_W-1:0] tag,
                                                  logic [PRI_W-1:0] rank);
        rsp_word_t r;
        int        pos;
        r.status       = STAT_OK;
        r.out_id       = '0;
        r.out_priority = '0;
        case (op)
            MODE_INSERT:
            begin
                if (list_len >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    // goes ahead of the first entry that is strictly less urgent
                    pos = list_len;
                    for (int i = 0; i < list_len; i++)
                    begin
                        if (list_rank[i] > rank)
                        begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = list_len; i > pos; i--)
                    begin
                        list_tag[i]  = list_tag[i - 1];
                        list_rank[i] = list_rank[i - 1];
                    end
                    list_tag[pos]  = tag;
                    list_rank[pos] = rank;
                    list_len++;
                end
            end
            MODE_ADMIT:
            begin
                if (list_len == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.out_id       = list_tag[0];
                    r.out_priority = list_rank[0];
                    drop_entry(0);
                end
            end
            MODE_UPDATE:
            begin
                pos = find_tag(tag);
                if (pos < 0)
                    r.status = STAT_NOT_FOUND;
                else
                    list_rank[pos] = rank;
            end
            default:
            begin
                if (list_len == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    pos = find_tag(tag);
                    if (pos < 0)
                        r.status = STAT_NOT_FOUND;
                    else
                    begin
                        r.out_id       = list_tag[pos];
                        r.out_priority = list_rank[pos];
                        drop_entry(pos);
                    end
                end
            end
        endcase
        r.occupancy = OCC_W'(list_len);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatch_count < 30)
            $display("MISMATCH at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_word(mode_t op, logic [ID_W-1:0] tag, logic [PRI_W-1:0] rank);
        int unsigned gap;
        gap = send_idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= op;
        req_ch.item_id      <= tag;
        req_ch.priority_req <= rank;
        do
            @(posedge clk);
        while (!req_ch.ready);
        awaited_rsp.push_back(queue_op_result(op, tag, rank));
        sent_words++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_rsp.size() != 0);
    endtask

    // half the time an id already held, so update and remove find matches
    function automatic logic [ID_W-1:0] pick_tag();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5 && list_len > 0)
            return list_tag[$urandom_range(0, list_len - 1)];
        else if (r < 8)
            return ID_W'($urandom_range(0, 15));
        return ID_W'($urandom());
    endfunction

    function automatic logic [PRI_W-1:0] pick_rank();
        if ($urandom_range(0, 9) == 0)
            return 2'd0;
        return PRI_W'($urandom_range(1, 3));
    endfunction

    function automatic mode_t pick_mode(seg_kind_t kind);
        int unsigned w;
        int          ins_top;
        int          adm_top;
        int          upd_top;
        w = $urandom_range(0, 99);
        case (kind)
            SEG_FILL:
            begin
                ins_top = 60; adm_top = 70; upd_top = 85;
            end
            SEG_DRAIN:
            begin
                ins_top = 15; adm_top = 55; upd_top = 70;
            end
            default:
            begin
                ins_top = 30; adm_top = 55; upd_top = 75;
            end
        endcase
        if (w < ins_top)
            return MODE_INSERT;
        else if (w < adm_top)
            return MODE_ADMIT;
        else if (w < upd_top)
            return MODE_UPDATE;
        return MODE_REMOVE;
    endfunction

    task automatic test_empty_list();
        send_word(MODE_ADMIT,  16'h0000, 2'd1);
        send_word(MODE_REMOVE, 16'h0000, 2'd1);
        send_word(MODE_UPDATE, 16'h0000, 2'd2);
    endtask

    // equal ranks keep arrival order; rank zero outranks one
    task automatic test_ordering();
        send_word(MODE_INSERT, 16'hFFFF, 2'd2);
        send_word(MODE_INSERT, 16'h0000, 2'd1);
        send_word(MODE_INSERT, 16'hA5A5, 2'd3);
        send_word(MODE_INSERT, 16'h5A5A, 2'd0);
        send_word(MODE_INSERT, 16'h1234, 2'd2);
        send_word(MODE_INSERT, 16'hFFFF, 2'd1);
    endtask

    // duplicate ids: update and remove hit the first match from the head
    task automatic test_id_match();
        send_word(MODE_UPDATE, 16'hFFFF, 2'd3);
        send_word(MODE_UPDATE, 16'h7777, 2'd1);
        send_word(MODE_REMOVE, 16'hFFFF, 2'd2);
        send_word(MODE_REMOVE, 16'h7777, 2'd2);
        send_word(MODE_ADMIT,  16'h0000, 2'd0);
        send_word(MODE_ADMIT,  16'h0000, 2'd0);
    endtask

    task automatic test_full_list();
        while (list_len < CAPACITY)
            send_word(MODE_INSERT, ID_W'($urandom_range(0, 15)), pick_rank());
        send_word(MODE_INSERT, 16'hFFFF, 2'd1);
        send_word(MODE_UPDATE, list_tag[CAPACITY - 1], 2'd0);
        send_word(MODE_REMOVE, list_tag[CAPACITY / 2], 2'd3);
        send_word(MODE_INSERT, 16'h8001, 2'd3);
        send_word(MODE_INSERT, 16'h8002, 2'd0);
        while (list_len > 0)
            send_word(MODE_ADMIT, pick_tag(), pick_rank());
        send_word(MODE_ADMIT, 16'h0000, 2'd1);
    endtask

    task automatic test_random_traffic();
        seg_kind_t kind;
        for (int seg = 0; seg < 16; seg++)
        begin
            kind         = seg_kind_t'(seg % 3);
            send_idle_on = (seg % 4 != 3);
            recv_idle_on = (seg % 4 != 3) && (seg % 4 != 1);
            for (int n = 0; n < 96; n++)
                send_word(pick_mode(kind), pick_tag(), pick_rank());
            if (seg % 6 == 5)
                wait_drained();
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, awaited_rsp.size());
            $display("stable_priority_queue_by_id test failed");
            $finish;
        end
    end

    initial
    begin : rsp_checker
        rsp_word_t   want;
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = recv_idle_on ? $urandom_range(0, 9) : 0;
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            got_words++;
            status_seen[rsp_ch.status]++;
            if (awaited_rsp.size() == 0)
                report_mismatch("response with none pending, status", rsp_ch.status, 0);
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", rsp_ch.status, want.status);
                if (rsp_ch.out_id !== want.out_id)
                    report_mismatch("out_id", rsp_ch.out_id, want.out_id);
                if (rsp_ch.out_priority !== want.out_priority)
                    report_mismatch("out_priority", rsp_ch.out_priority, want.out_priority);
                if (rsp_ch.occupancy !== want.occupancy)
                    report_mismatch("occupancy", rsp_ch.occupancy, want.occupancy);
            end
        end
    end

    initial
    begin
        sent_words          = 0;
        list_len            = 0;
        send_idle_on        = 1'b1;
        recv_idle_on        = 1'b1;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= MODE_INSERT;
        req_ch.item_id      <= '0;
        req_ch.priority_req <= '0;
        rsp_ch.ready        <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_ordering();
        test_id_match();
        test_full_list();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("sent %0d words, checked %0d responses, %0d left pending",
                 sent_words, got_words, awaited_rsp.size());
        $display("status mix: ok %0d, empty %0d, not found %0d, full %0d",
                 status_seen[STAT_OK], status_seen[STAT_EMPTY],
                 status_seen[STAT_NOT_FOUND], status_seen[STAT_FULL]);
        if (mismatch_count == 0 && awaited_rsp.size() == 0)
            $display("stable_priority_queue_by_id test passed");
        else
            $display("stable_priority_queue_by_id test failed");
        $finish;
    end

endmodule
`default_nettype wire
